// File: hdl/bnis_pkg.sv
// shared types and constants for the batch-norm scale/shift block
`default_nettype none
package bnis_pkg;
    localparam int CHANNELS = 16;
    localparam int CH_W     = 4;
    localparam logic [15:0] EPS_RESET = 16'd1;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_PROCESS = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic [3:0]  channel;
        logic [31:0] sample_value;
        logic [31:0] gamma_value;
        logic [31:0] beta_value;
        logic [31:0] mean_value;
        logic [30:0] variance_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_value;
        logic        saturated;
    } out_item_t;

    // one table entry: scale, shift and the load-time clip flag
    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] shift;
        logic        clipped;
    } entry_t;

    typedef struct packed {
        logic           we;
        logic [CH_W-1:0] waddr;
        entry_t         wdata;
    } tbl_wr_t;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) r = {1'b1, Q_MAX};
        else if (v < -64'sd2147483648) r = {1'b1, Q_MIN};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hdl/bnis_table.sv
// per-channel scale/shift memory, one write and one registered read port
`default_nettype none
module bnis_table (
    input  wire logic                       aclk,
    input  wire bnis_pkg::tbl_wr_t          wr,
    input  wire logic                       rd_en,
    input  wire logic [bnis_pkg::CH_W-1:0]  rd_addr,
    output bnis_pkg::entry_t                rd_data
);
    bnis_pkg::entry_t mem [bnis_pkg::CHANNELS];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: hdl/bnis_loader.sv
// load path: isqrt, rounded divide and shift term, one bit per cycle
`default_nettype none
module bnis_loader (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire bnis_pkg::in_item_t        item,
    input  wire logic [15:0]               epsilon,
    output logic                           busy,
    output bnis_pkg::tbl_wr_t              wr
);
    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_SQRT = 6'b000010,
        L_DIV  = 6'b000100,
        L_SCL  = 6'b001000,
        L_MUL  = 6'b010000,
        L_WR   = 6'b100000
    } lstate_t;

    lstate_t           state_reg, state_next;
    logic [5:0]        cnt_reg;
    logic [3:0]        ch_reg;
    logic [31:0]       gamma_reg, beta_reg, mean_reg;
    // sqrt of a 48-bit radicand: 24 bit pairs
    logic [47:0]       rad_reg;
    logic [25:0]       rem_reg;
    logic [23:0]       root_reg;
    // divide of 48-bit magnitude by 24-bit root
    logic [47:0]       num_reg;
    logic [24:0]       drem_reg;
    logic [47:0]       quo_reg;
    logic [31:0]       scale_reg;
    logic              clip_reg;
    logic signed [63:0] prod_reg;

    logic [25:0]       trial;
    logic [24:0]       dsh;
    logic [47:0]       var_eps;
    logic [31:0]       gmag;
    logic [48:0]       qr;
    logic signed [49:0] sq;
    logic [32:0]       s_sat;
    logic signed [63:0] diff;
    logic [32:0]       h_sat;

    // busy also covers the cycle in which the table write lands
    assign busy = (state_reg != L_IDLE) || wr.we;
    assign trial = {rem_reg[23:0], rad_reg[47:46]} - {root_reg, 2'b01};
    assign dsh = {drem_reg[23:0], num_reg[47]};
    assign var_eps = {17'd0, item.variance_value} + {32'd0, epsilon};
    assign gmag = gamma_reg[31] ? (~gamma_reg + 32'd1) : gamma_reg;
    // round to nearest: remainder*2 >= divisor
    assign qr = {1'b0, quo_reg} + {48'd0, ({drem_reg, 1'b0} >= {2'b00, root_reg})};
    assign sq = gamma_reg[31] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    assign s_sat = bnis_pkg::sat32(64'(sq));
    assign diff = 64'($signed(beta_reg)) - (prod_reg >>> 16);
    assign h_sat = bnis_pkg::sat32(diff);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (start) state_next = L_SQRT;
            L_SQRT: if (cnt_reg == 6'd23) state_next = L_DIV;
            L_DIV:  if (cnt_reg == 6'd47) state_next = L_SCL;
            L_SCL:  state_next = L_MUL;
            L_MUL:  state_next = L_WR;
            L_WR:   state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) cnt_reg <= '0;
            else cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) wr.we <= 1'b0;
        else wr.we <= (state_reg == L_WR);
        unique case (state_reg)
            L_IDLE: begin
                ch_reg    <= item.channel;
                gamma_reg <= item.gamma_value;
                beta_reg  <= item.beta_value;
                mean_reg  <= item.mean_value;
                rad_reg   <= {var_eps[31:0], 16'd0};
                rem_reg   <= '0;
                root_reg  <= '0;
                clip_reg  <= 1'b0;
            end
            L_SQRT: begin
                rad_reg <= {rad_reg[45:0], 2'b00};
                if (!trial[25]) begin
                    rem_reg  <= trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= {rem_reg[23:0], rad_reg[47:46]};
                    root_reg <= {root_reg[22:0], 1'b0};
                end
                num_reg  <= {gmag, 16'd0};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            L_DIV: begin
                num_reg <= {num_reg[46:0], 1'b0};
                if (dsh >= {1'b0, root_reg}) begin
                    drem_reg <= dsh - {1'b0, root_reg};
                    quo_reg  <= {quo_reg[46:0], 1'b1};
                end else begin
                    drem_reg <= dsh;
                    quo_reg  <= {quo_reg[46:0], 1'b0};
                end
            end
            L_SCL: begin
                if (root_reg == '0) begin
                    // zero root: clip by sign of gamma
                    if (gamma_reg == '0) begin
                        scale_reg <= '0;
                    end else begin
                        scale_reg <= gamma_reg[31] ? bnis_pkg::Q_MIN : bnis_pkg::Q_MAX;
                        clip_reg  <= 1'b1;
                    end
                end else begin
                    scale_reg <= s_sat[31:0];
                    clip_reg  <= s_sat[32];
                end
            end
            L_MUL: begin
                prod_reg <= $signed(mean_reg) * $signed(scale_reg) + 64'sd32768;
            end
            L_WR: begin
                wr.waddr         <= ch_reg;
                wr.wdata.scale   <= scale_reg;
                wr.wdata.shift   <= h_sat[31:0];
                wr.wdata.clipped <= clip_reg | h_sat[32];
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/batchnorm_inference_scale_shift.sv
// top level of the batch-norm inference scale/shift block
//
// channels: s_ beats carry a command; a load beat (command 0) sets one
// channel's scale and shift from gamma, beta, mean and variance and makes
// no m_ beat; a process beat (command 1) yields one m_ beat holding
// sample*scale + shift, rounded and saturated, with a saturation flag.
// cfg_ beats write epsilon; the user must send them only while the block
// is idle; the block itself does not enforce this. throughput: process
// beats stream one per cycle unless the receiver stalls or a load is in
// progress; results pass the table read, multiply and round/saturate
// stages. a load keeps the block busy through the bit-serial square root
// (24 steps) and restoring divide (48 steps). a receiver stall holds the
// pipe; s_ready drops when the last stage holds a beat that is not taken,
// and while the loader is busy. reset clears the pipe valids, the loader
// and sets epsilon to 1; the tables are undefined until loaded
`default_nettype none
module batchnorm_inference_scale_shift (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bnis_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bnis_pkg::out_item_t       m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [15:0]          cfg_data
);
    logic [15:0]        eps_reg;
    logic               ld_busy;
    bnis_pkg::tbl_wr_t  wr;
    bnis_pkg::entry_t   rd_data;
    logic               adv;
    logic               s_acc, ld_start, proc_acc;
    // stage 1: table read in flight
    logic               v1_reg;
    logic [31:0]        x1_reg;
    // stage 2: product
    logic               v2_reg;
    logic signed [63:0] p2_reg;
    logic [31:0]        h2_reg;
    logic               c2_reg;
    logic signed [63:0] acc;
    logic [32:0]        r_sat;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) eps_reg <= bnis_pkg::EPS_RESET;
        else if (cfg_valid) eps_reg <= cfg_data;
    end

    // whole pipe advances unless the output beat is stalled
    assign adv      = !m_valid || m_ready;
    assign s_ready  = adv && !ld_busy;
    assign s_acc    = s_valid && s_ready;
    assign ld_start = s_acc && (s_data.command == bnis_pkg::CMD_LOAD);
    assign proc_acc = s_acc && (s_data.command == bnis_pkg::CMD_PROCESS);

    bnis_loader u_loader (
        .aclk(aclk), .aresetn(aresetn), .start(ld_start), .item(s_data),
        .epsilon(eps_reg), .busy(ld_busy), .wr(wr)
    );

    bnis_table u_table (
        .aclk(aclk), .wr(wr), .rd_en(adv), .rd_addr(s_data.channel),
        .rd_data(rd_data)
    );

    // rounding: add half lsb, arithmetic shift floors
    assign acc   = p2_reg + $signed({h2_reg, 16'd0}) + 64'sd32768;
    assign r_sat = bnis_pkg::sat32(acc >>> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v1_reg  <= proc_acc;
            v2_reg  <= v1_reg;
            m_valid <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg <= s_data.sample_value;
            p2_reg <= $signed(x1_reg) * $signed(rd_data.scale);
            h2_reg <= rd_data.shift;
            c2_reg <= rd_data.clipped;
            m_data.out_value <= r_sat[31:0];
            m_data.saturated <= r_sat[32] | c2_reg;
        end
    end
endmodule
`default_nettype wire
